### src/tmac_pkg.sv
package tmac_pkg;

    // Sample and arithmetic widths.
    localparam int SAMPLE_W   = 12;
    localparam int RAW_W      = 16;
    localparam int COEF_W     = 24;
    localparam int OFFS_W     = 32;
    localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W      = 40;
    localparam int FRAC_BITS  = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL  = 12'hFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_EMPTY = 12'h000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_X_FROM_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_FROM_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FROM_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FROM_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd7;

    // Calibration values after reset.
    localparam logic signed [COEF_W-1:0] RST_X_FROM_X = 24'sd70644;
    localparam logic signed [COEF_W-1:0] RST_X_FROM_Y = 24'sd680;
    localparam logic signed [OFFS_W-1:0] RST_X_OFFSET = -32'sd17420583;
    localparam logic signed [COEF_W-1:0] RST_Y_FROM_X = 24'sd724;
    localparam logic signed [COEF_W-1:0] RST_Y_FROM_Y = -24'sd94727;
    localparam logic signed [OFFS_W-1:0] RST_Y_OFFSET = 32'sd367306531;
    localparam logic [SAMPLE_W-1:0]      RST_X_MAX    = 12'd239;
    localparam logic [SAMPLE_W-1:0]      RST_Y_MAX    = 12'd319;

    typedef struct packed {
        logic signed [COEF_W-1:0] x_from_x;
        logic signed [COEF_W-1:0] x_from_y;
        logic signed [OFFS_W-1:0] x_offset;
        logic signed [COEF_W-1:0] y_from_x;
        logic signed [COEF_W-1:0] y_from_y;
        logic signed [OFFS_W-1:0] y_offset;
        logic [SAMPLE_W-1:0]      x_max;
        logic [SAMPLE_W-1:0]      y_max;
    } t_cal;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GATHER,
        S_AXEND,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_PEN_UP,
        OP_SAMPLE,
        OP_LATCH_X,
        OP_LATCH_Y,
        OP_MUL_XX,
        OP_MUL_XY,
        OP_MUL_YX,
        OP_MUL_YY,
        OP_ACC_LAST,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Clamp a Q20 value to 0..maxv and round half up.
    function automatic logic [SAMPLE_W-1:0] map_axis(
        input logic signed [ACC_W-1:0] v,
        input logic [SAMPLE_W-1:0]     maxv
    );
        logic signed [ACC_W-1:0] lim;
        logic signed [ACC_W-1:0] rnd;
        logic [SAMPLE_W-1:0]     res;
        lim = $signed({{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, maxv, {FRAC_BITS{1'b0}}});
        rnd = v + $signed({{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
        if (v <= 0) begin
            res = '0;
        end else if (v >= lim) begin
            res = maxv;
        end else begin
            res = rnd[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

### src/tmac_regs.sv
module tmac_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tmac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tmac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tmac_pkg::t_cal                      o_cal
);
    import tmac_pkg::*;

    t_cal r_cal;

    // Calibration register file, written one register at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.x_from_x <= RST_X_FROM_X;
            r_cal.x_from_y <= RST_X_FROM_Y;
            r_cal.x_offset <= RST_X_OFFSET;
            r_cal.y_from_x <= RST_Y_FROM_X;
            r_cal.y_from_y <= RST_Y_FROM_Y;
            r_cal.y_offset <= RST_Y_OFFSET;
            r_cal.x_max    <= RST_X_MAX;
            r_cal.y_max    <= RST_Y_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_FROM_X: r_cal.x_from_x <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_X_FROM_Y: r_cal.x_from_y <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_X_OFFSET: r_cal.x_offset <= $signed(i_cfg_data[OFFS_W-1:0]);
                REG_Y_FROM_X: r_cal.y_from_x <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_Y_FROM_Y: r_cal.y_from_y <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_Y_OFFSET: r_cal.y_offset <= $signed(i_cfg_data[OFFS_W-1:0]);
                REG_X_MAX:    r_cal.x_max    <= i_cfg_data[SAMPLE_W-1:0];
                REG_Y_MAX:    r_cal.y_max    <= i_cfg_data[SAMPLE_W-1:0];
                default:      r_cal.x_max    <= r_cal.x_max;
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

### src/tmac_ctrl.sv
module tmac_ctrl #(
    parameter int SAMPLES_PER_AXIS = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_pen_down,
    input  tmac_pkg::t_dp_status    i_status,
    output tmac_pkg::t_dp_cmd       o_cmd
);
    import tmac_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES_PER_AXIS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_AXIS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_axis, n_axis;
    logic             accept;

    // State and sample counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_axis  <= n_axis;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_axis     = r_axis;
        o_cmd.op   = OP_NONE;
        o_cmd.first = (r_idx == '0);
        o_in_ready = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.out_free;
                accept     = i_in_valid && i_status.out_free;
                if (accept) begin
                    if (i_pen_down) begin
                        o_cmd.op = OP_START;
                        n_idx    = IDX_W'(1);
                        n_axis   = 1'b0;
                        n_state  = S_GATHER;
                    end else begin
                        o_cmd.op = OP_PEN_UP;
                    end
                end
            end
            S_GATHER: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                if (accept) begin
                    o_cmd.op = OP_SAMPLE;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_AXEND;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_AXEND: begin
                if (!r_axis) begin
                    o_cmd.op = OP_LATCH_X;
                    n_axis   = 1'b1;
                    n_state  = S_GATHER;
                end else begin
                    o_cmd.op = OP_LATCH_Y;
                    n_axis   = 1'b0;
                    n_state  = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.op = OP_MUL_XX;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL_XY;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_MUL_YX;
                n_state  = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.op = OP_MUL_YY;
                n_state  = S_MUL4;
            end
            S_MUL4: begin
                o_cmd.op = OP_ACC_LAST;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/tmac_dp.sv
module tmac_dp #(
    parameter int SAMPLES_PER_AXIS = 5,
    parameter int MIN_VALID        = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tmac_pkg::t_dp_cmd                   i_cmd,
    output tmac_pkg::t_dp_status                o_status,
    input  logic [tmac_pkg::RAW_W-1:0]          i_raw_word,
    input  tmac_pkg::t_cal                      i_cal,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_pressed,
    output logic                                o_point_valid,
    output logic [tmac_pkg::SAMPLE_W-1:0]       o_coord_x,
    output logic [tmac_pkg::SAMPLE_W-1:0]       o_coord_y
);
    import tmac_pkg::*;

    localparam int KEEP  = SAMPLES_PER_AXIS - 1;
    localparam int CNT_W = $clog2(SAMPLES_PER_AXIS);

    logic [SAMPLE_W-1:0]     r_keep [KEEP];
    logic [SAMPLE_W-1:0]     n_keep [KEEP];
    logic [CNT_W-1:0]        r_count;
    logic [SAMPLE_W-1:0]     r_x_med, r_y_med;
    logic                    r_x_ok, r_y_ok;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic                    r_out_valid;
    logic                    r_out_pressed, r_out_point;
    logic [SAMPLE_W-1:0]     r_out_x, r_out_y;

    logic [SAMPLE_W-1:0]     sample;
    logic                    keepable;
    logic [KEEP-1:0]         le;
    logic [CNT_W-1:0]        med_idx;
    logic [SAMPLE_W-1:0]     med;
    logic                    axis_ok;
    logic signed [COEF_W-1:0] mul_coef;
    logic [SAMPLE_W-1:0]     mul_raw;
    logic signed [PROD_W-1:0] mul_full;
    logic                    both_ok;

    // Sample field and the drop rule for the first, empty and saturated samples.
    assign sample   = i_raw_word[SAMPLE_W+2:3];
    assign keepable = !i_cmd.first && (sample != SAMPLE_EMPTY) && (sample != SAMPLE_FULL)
                      && (r_count < CNT_W'(KEEP));

    // Sorted insertion: entries at or below the new sample stay, the rest move up one.
    always_comb begin
        for (int i = 0; i < KEEP; i++) begin
            le[i] = (CNT_W'(i) < r_count) && (r_keep[i] <= sample);
        end
        n_keep[0] = le[0] ? r_keep[0] : sample;
        for (int i = 1; i < KEEP; i++) begin
            if (le[i]) begin
                n_keep[i] = r_keep[i];
            end else if (le[i-1]) begin
                n_keep[i] = sample;
            end else begin
                n_keep[i] = r_keep[i-1];
            end
        end
    end

    // Lower median of the sorted list.
    always_comb begin
        med_idx = (r_count - CNT_W'(1)) >> 1;
        med     = '0;
        for (int i = 0; i < KEEP; i++) begin
            if (CNT_W'(i) == med_idx) begin
                med = r_keep[i];
            end
        end
        axis_ok = (int'(r_count) >= MIN_VALID);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SAMPLE && keepable) begin
            r_keep <= n_keep;
        end
    end

    // Kept sample count and axis flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_x_ok  <= 1'b0;
            r_y_ok  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_START: begin
                    r_count <= '0;
                end
                OP_SAMPLE: begin
                    if (keepable) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_LATCH_X: begin
                    r_x_ok  <= axis_ok;
                    r_count <= '0;
                end
                OP_LATCH_Y: begin
                    r_y_ok  <= axis_ok;
                    r_count <= '0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_XX: begin
                mul_coef = i_cal.x_from_x;
                mul_raw  = r_x_med;
            end
            OP_MUL_XY: begin
                mul_coef = i_cal.x_from_y;
                mul_raw  = r_y_med;
            end
            OP_MUL_YX: begin
                mul_coef = i_cal.y_from_x;
                mul_raw  = r_x_med;
            end
            OP_MUL_YY: begin
                mul_coef = i_cal.y_from_y;
                mul_raw  = r_y_med;
            end
            default: begin
                mul_coef = '0;
                mul_raw  = '0;
            end
        endcase
    end

    // Full-width signed product of the selected coefficient and median.
    assign mul_full = mul_coef * $signed({1'b0, mul_raw});

    // Medians, product register and the two Q20 accumulators.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_full;
        unique case (i_cmd.op)
            OP_LATCH_X: begin
                r_x_med <= med;
            end
            OP_LATCH_Y: begin
                r_y_med <= med;
                r_acc_x <= ACC_W'(i_cal.x_offset);
                r_acc_y <= ACC_W'(i_cal.y_offset);
            end
            OP_MUL_XY, OP_MUL_YX: begin
                r_acc_x <= r_acc_x + ACC_W'(r_prod);
            end
            OP_MUL_YY, OP_ACC_LAST: begin
                r_acc_y <= r_acc_y + ACC_W'(r_prod);
            end
            default: begin
                r_acc_x <= r_acc_x;
            end
        endcase
    end

    assign both_ok = r_x_ok && r_y_ok;

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_PEN_UP || i_cmd.op == OP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PEN_UP) begin
            r_out_pressed <= 1'b0;
            r_out_point   <= 1'b0;
            r_out_x       <= '0;
            r_out_y       <= '0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_out_pressed <= 1'b1;
            r_out_point   <= both_ok;
            r_out_x       <= both_ok ? map_axis(r_acc_x, i_cal.x_max) : '0;
            r_out_y       <= both_ok ? map_axis(r_acc_y, i_cal.y_max) : '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pressed         = r_out_pressed;
    assign o_point_valid     = r_out_point;
    assign o_coord_x         = r_out_x;
    assign o_coord_y         = r_out_y;

    // An invalid point always reports zero coordinates.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_point) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("invalid point with nonzero coordinates");

    // A valid point only comes from a pressed read.
    a_valid_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_point) |-> r_out_pressed)
        else $error("valid point without pen down");

    // The kept list never overflows its slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(KEEP))
        else $error("kept sample count out of range");

endmodule

### src/touch_median_affine_calibrator_unit.sv
// Resistive touch reader: per-axis median filter followed by affine calibration.
//
// Input stream: one converter word per transaction. s_axis_tuser carries the pen
// level, which is looked at only on the first transaction of a read. Pen up gives
// one result at once (not pressed, not valid, zero coordinates). Pen down starts a
// read: that word and the next SAMPLES_PER_AXIS-1 words are X samples, followed by
// SAMPLES_PER_AXIS Y samples. The first sample of each axis and samples of 0 or
// 4095 are dropped; the lower median of the rest is kept.
// Output stream: one result per read. After the last Y sample the Y median is latched,
// the shared 24x13 multiplier forms the XX, XY, YX and YY products in turn, the last
// product is accumulated and the result waits for a free output register. A read takes
// 2*SAMPLES_PER_AXIS accepted transactions plus an axis-end step between the axes.
// Configuration: eight calibration registers written by index through i_cfg_*; write
// only while no read is in progress. The block itself does not enforce this.
// Reset (synchronous, active low) restores the default calibration and empties the
// output register. When the receiver stalls, the result waits in the output
// register; sample transactions are still taken, but a new read and the final
// result wait for the register to free up.
module touch_median_affine_calibrator_unit #(
    parameter int SAMPLES_PER_AXIS = 5,
    parameter int MIN_VALID        = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tmac_pkg::RAW_W-1:0]          s_axis_tdata,  // [15:0] raw_word
    input  logic                                s_axis_tuser,  // [0] pen_down
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*tmac_pkg::SAMPLE_W-1:0]     m_axis_tdata,  // [11:0] coord_x, [23:12] coord_y
    output logic [1:0]                          m_axis_tuser,  // [0] pressed, [1] point_valid
    input  logic                                i_cfg_we,
    input  logic [tmac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tmac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tmac_pkg::*;

    t_cal                cal;
    t_dp_cmd             cmd;
    t_dp_status          status;
    logic                pressed, point_valid;
    logic [SAMPLE_W-1:0] coord_x, coord_y;

    tmac_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cal      (cal)
    );

    tmac_ctrl #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_pen_down (s_axis_tuser),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tmac_dp #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
        .MIN_VALID        (MIN_VALID)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_raw_word    (s_axis_tdata),
        .i_cal         (cal),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_pressed     (pressed),
        .o_point_valid (point_valid),
        .o_coord_x     (coord_x),
        .o_coord_y     (coord_y)
    );

    // Pack the result fields onto the output stream.
    assign m_axis_tdata = {coord_y, coord_x};
    assign m_axis_tuser = {point_valid, pressed};

endmodule
